// ===== rtl/core/esc_pkg.sv =====
// shared types, constants and register indexes of the sensor compensation core
package esc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_HUM_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRES_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRES_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_PRES_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM_A   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM_B   = 3'd6;

  // skip markers of the raw codes
  localparam logic [19:0] SKIP20_LO = 20'h80000;
  localparam logic [19:0] SKIP20_HI = 20'hFFFFF;
  localparam logic [15:0] SKIP16_LO = 16'h8000;
  localparam logic [15:0] SKIP16_HI = 16'hFFFF;

  // queue depths
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // quotient bits of the pressure divider
  localparam int QUO_W = 64;

  typedef struct packed {
    logic        hum_present;
    logic [47:0] temp;
    logic [47:0] pres_a;
    logic [47:0] pres_b;
    logic [47:0] pres_c;
    logic [39:0] hum_a;
    logic [31:0] hum_b;
  } cal_t;

  typedef struct packed {
    logic [19:0] at;
    logic [19:0] ap;
    logic [15:0] ah;
    logic        tv;
    logic        pv;
    logic        hv;
  } item_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [31:0] pres;
    logic [16:0] hum;
    logic        tv;
    logic        pv;
    logic        hv;
  } result_t;

endpackage

// ===== rtl/core/esc_fifo.sv =====
// small synchronous queue used between the front, the back and the result side
module esc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/esc_front.sv =====
// front end: takes raw readings, flags skipped channels and hands them to the queue
module esc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          hum_present,
  input  logic          push,
  output logic          full,
  input  logic [19:0]   at,
  input  logic [19:0]   ap,
  input  logic [15:0]   ah,
  input  logic          mid_full,
  output logic          mid_push,
  output esc_pkg::item_t mid_item
);
  import esc_pkg::*;

  logic  vld;
  item_t item;
  logic  take;
  logic  tv_c;
  logic  pv_c;
  logic  hv_c;

  assign full     = vld && mid_full;
  assign take     = push && !full;
  assign mid_push = vld && !mid_full;
  assign mid_item = item;

  // channel classification
  always_comb begin
    tv_c = !(at == SKIP20_LO || at == SKIP20_HI);
    pv_c = tv_c && !(ap == SKIP20_LO || ap == SKIP20_HI);
    hv_c = tv_c && hum_present && !(ah == SKIP16_LO || ah == SKIP16_HI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (mid_push) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= '{at: at, ap: ap, ah: ah, tv: tv_c, pv: pv_c, hv: hv_c};
    end
  end

endmodule

// ===== rtl/core/esc_div.sv =====
// pipelined signed 64 by 31 bit divider, one quotient bit per stage
module esc_div #(
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [63:0]        num,
  input  logic signed [30:0] den,
  input  logic [PW-1:0]      in_pay,
  output logic               out_vld,
  output logic [63:0]        quo,
  output logic [PW-1:0]      out_pay
);
  import esc_pkg::*;

  logic [31:0]   rem [QUO_W+1];
  logic [63:0]   dq  [QUO_W+1];
  logic [30:0]   dvs [QUO_W+1];
  logic          neg [QUO_W+1];
  logic          vld [QUO_W+1];
  logic [PW-1:0] pay [QUO_W+1];

  // entry stage: signs and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dq[0]  <= num[63] ? (~num + 64'd1) : num;
      dvs[0] <= den[30] ? 31'(~den + 31'd1) : 31'(den);
      neg[0] <= num[63] ^ den[30];
      pay[0] <= in_pay;
    end
  end

  // restoring steps
  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    logic [31:0] trial;
    logic        ge;

    assign trial = {rem[g][30:0], dq[g][63]};
    assign ge    = (trial >= {1'b0, dvs[g]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? (trial - {1'b0, dvs[g]}) : trial;
        dq[g+1]  <= {dq[g][62:0], ge};
        dvs[g+1] <= dvs[g];
        neg[g+1] <= neg[g];
        pay[g+1] <= pay[g];
      end
    end
  end

  // sign of the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo     <= neg[QUO_W] ? (~dq[QUO_W] + 64'd1) : dq[QUO_W];
      out_pay <= pay[QUO_W];
    end
  end

endmodule

// ===== rtl/core/esc_back.sv =====
// back end: compensation pipeline for temperature, humidity and pressure
module esc_back (
  input  logic             clk,
  input  logic             rst,
  input  esc_pkg::cal_t    cal,
  input  logic             mid_empty,
  input  esc_pkg::item_t   mid_item,
  output logic             mid_pop,
  input  logic             out_full,
  output logic             out_push,
  output esc_pkg::result_t out_res
);
  import esc_pkg::*;

  localparam int PW = $bits(result_t) + 1;

  // calibration fields
  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [7:0]         h1, h3;
  logic signed [15:0] h2, h4, h5;
  logic signed [7:0]  h6;

  assign t1 = cal.temp[15:0];
  assign t2 = cal.temp[31:16];
  assign t3 = cal.temp[47:32];
  assign p1 = cal.pres_a[15:0];
  assign p2 = cal.pres_a[31:16];
  assign p3 = cal.pres_a[47:32];
  assign p4 = cal.pres_b[15:0];
  assign p5 = cal.pres_b[31:16];
  assign p6 = cal.pres_b[47:32];
  assign p7 = cal.pres_c[15:0];
  assign p8 = cal.pres_c[31:16];
  assign p9 = cal.pres_c[47:32];
  assign h1 = cal.hum_a[7:0];
  assign h2 = cal.hum_a[23:8];
  assign h3 = cal.hum_a[31:24];
  assign h6 = cal.hum_a[39:32];
  assign h4 = cal.hum_b[15:0];
  assign h5 = cal.hum_b[31:16];

  logic adv;
  assign adv      = !out_full;
  assign mid_pop  = adv && !mid_empty;

  // stage valids
  logic [13:1] sv;
  logic [5:1]  uv;
  logic        dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
      uv <= '0;
    end else if (adv) begin
      sv <= {sv[12:1], mid_pop};
      uv <= {uv[4:1], dv};
    end
  end

  // per-stage payload
  result_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r, s11_r, s12_r, s13_r;
  result_t u1_r, u2_r, u3_r, u4_r, u5_r, d_r;
  logic [19:0] s1_ap, s2_ap, s3_ap, s4_ap, s5_ap, s6_ap, s7_ap;
  logic [15:0] s1_ah, s2_ah, s3_ah, s4_ah, s5_ah;

  // stage 1: temperature products
  logic signed [17:0] c1_td;
  logic signed [33:0] c1_v1p;
  logic signed [16:0] c1_d;
  logic signed [33:0] c1_dd;
  logic [31:0] s1_v1p, s1_dd;

  assign c1_td  = $signed({1'b0, mid_item.at[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign c1_v1p = c1_td * t2;
  assign c1_d   = $signed({1'b0, mid_item.at[19:4]}) - $signed({1'b0, t1});
  assign c1_dd  = c1_d * c1_d;

  // stage 2: second temperature term
  logic signed [35:0] c2_v2p;
  logic signed [31:0] s2_v1;
  logic [31:0]        s2_v2p;

  assign c2_v2p = $signed(s1_dd[31:12]) * t3;

  // stage 3: fine temperature
  logic signed [31:0] s3_fine;
  logic signed [31:0] c3_fine;

  assign c3_fine = s2_v1 + ($signed(s2_v2p) >>> 14);

  // stage 4: temperature and offsets
  logic signed [31:0] c4_f5;
  logic signed [31:0] c4_t128;
  logic signed [32:0] s4_pa;
  logic signed [31:0] s4_hv;

  assign c4_f5   = (s3_fine <<< 2) + s3_fine;
  assign c4_t128 = c4_f5 + 32'sd128;

  // stage 5: first pressure and humidity products
  logic signed [65:0] c5_aa;
  logic signed [47:0] c5_h5v;
  logic signed [40:0] c5_vh3;
  logic signed [39:0] c5_vh6;
  logic signed [63:0] s5_aa;
  logic signed [48:0] s5_ap5, s5_ap2;
  logic signed [31:0] s5_h5v, s5_vh3, s5_vh6;

  assign c5_aa  = s4_pa * s4_pa;
  assign c5_h5v = s4_hv * h5;
  assign c5_vh3 = s4_hv * $signed({1'b0, h3});
  assign c5_vh6 = s4_hv * h6;

  // stage 6: second-order pressure terms, humidity offsets
  logic signed [79:0] c6_aap6, c6_aap3;
  logic [63:0]        c6_bpart, c6_apart;
  logic [31:0]        c6_x1;
  logic signed [63:0] s6_aap6, s6_aap3;
  logic [63:0]        s6_bpart, s6_apart;
  logic signed [31:0] s6_x, s6_y0, s6_z;

  assign c6_aap6  = s5_aa * p6;
  assign c6_aap3  = s5_aa * p3;
  assign c6_bpart = ({{15{s5_ap5[48]}}, s5_ap5} << 17) + ({{48{p4[15]}}, p4} << 35);
  assign c6_apart = {{15{s5_ap2[48]}}, s5_ap2} << 12;
  assign c6_x1    = {2'b00, s5_ah, 14'd0} - {h4[11:0], 20'd0} - s5_h5v;

  // stage 7: pressure sums, humidity product
  logic signed [63:0] c7_zy;
  logic [63:0]        s7_b;
  logic signed [63:0] s7_a2;
  logic signed [31:0] s7_zy, s7_x;

  assign c7_zy = s6_z * s6_y0;

  // stage 8: divisor product and numerator
  logic signed [80:0] c8_a3p;
  logic [20:0]        c8_pval;
  logic signed [31:0] c8_y1;
  logic signed [47:0] c8_y2p;
  logic [63:0]        s8_a3p, s8_pn;
  logic signed [31:0] s8_y2p, s8_x;

  assign c8_a3p  = $signed(s7_a2 + 64'sh0000_8000_0000_0000) * $signed({1'b0, p1});
  assign c8_pval = 21'd1048576 - {1'b0, s7_ap};
  assign c8_y1   = (s7_zy >>> 10) + 32'sd2097152;
  assign c8_y2p  = c8_y1 * h2;

  // stage 9: divisor and scaled numerator
  logic [76:0]        c9_num;
  logic signed [30:0] s9_a3;
  logic [63:0]        s9_num;
  logic signed [31:0] s9_y, s9_x;

  assign c9_num = s8_pn * 13'd3125;

  // stages 10 to 13: humidity tail
  logic signed [63:0] c10_v;
  logic signed [31:0] s10_v, s11_v, s12_v;
  logic signed [33:0] c11_qq;
  logic [31:0]        s11_qq;
  logic signed [33:0] c12_r;
  logic [31:0]        s12_hp;
  logic signed [31:0] c13_w;
  logic [28:0]        c13_wc;
  logic [26:0]        c13_prod;
  logic signed [30:0] s10_a3, s11_a3, s12_a3, s13_a3;
  logic [63:0]        s10_num, s11_num, s12_num, s13_num;

  assign c10_v    = s9_x * s9_y;
  assign c11_qq   = $signed(s10_v[31:15]) * $signed(s10_v[31:15]);
  assign c12_r    = $signed(s11_qq[31:7]) * $signed({1'b0, h1});
  assign c13_w    = s12_v - ($signed(s12_hp) >>> 4);
  assign c13_prod = c13_wc[28:12] * 10'd1000;

  // clamp to the valid humidity range
  always_comb begin
    if (c13_w < 0) begin
      c13_wc = '0;
    end else if (c13_w > 32'sd419430400) begin
      c13_wc = 29'd419430400;
    end else begin
      c13_wc = c13_w[28:0];
    end
  end

  // divider
  logic        dz;
  logic [63:0] dq;
  logic [PW-1:0] d_pay;

  esc_div #(.PW(PW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (sv[13]),
    .num    (s13_num),
    .den    (s13_a3),
    .in_pay ({s13_r, (s13_a3 == '0)}),
    .out_vld(dv),
    .quo    (dq),
    .out_pay(d_pay)
  );

  assign d_r = d_pay[PW-1:1];
  assign dz  = d_pay[0];

  // pressure tail after the division
  logic signed [63:0] c_u1_mq;
  logic signed [79:0] c_u1_pm, c_u1_p8p;
  logic signed [63:0] u1_p, u1_mq, u1_pm, u1_p8p;
  logic               u1_z, u2_z, u3_z, u4_z;
  logic [63:0]        c_u2_c, c_u2_d;
  logic [63:0]        u2_ll;
  logic [31:0]        u2_cr;
  logic signed [63:0] u2_p, u2_b2;
  logic signed [63:0] u3_p, u3_a, u3_b2;
  logic signed [63:0] c_u4_sum;
  logic signed [63:0] u4_pn;
  logic [63:0]        c_u5_x;

  assign c_u1_mq  = $signed(dq) >>> 13;
  assign c_u1_pm  = c_u1_mq * p9;
  assign c_u1_p8p = $signed(dq) * p8;
  assign c_u2_c   = u1_pm[63:32] * u1_mq[31:0];
  assign c_u2_d   = u1_pm[31:0] * u1_mq[63:32];
  assign c_u4_sum = u3_p + u3_a + u3_b2;
  assign c_u5_x   = (u4_pn <<< 3) + (u4_pn <<< 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      s1_r   <= '{temp: '0, fine: '0, pres: '0, hum: '0,
                  tv: mid_item.tv, pv: mid_item.pv, hv: mid_item.hv};
      s1_ap  <= mid_item.ap;
      s1_ah  <= mid_item.ah;
      s1_v1p <= c1_v1p[31:0];
      s1_dd  <= c1_dd[31:0];
      // stage 2
      s2_r   <= s1_r;
      s2_ap  <= s1_ap;
      s2_ah  <= s1_ah;
      s2_v1  <= $signed(s1_v1p) >>> 11;
      s2_v2p <= c2_v2p[31:0];
      // stage 3
      s3_r   <= s2_r;
      s3_ap  <= s2_ap;
      s3_ah  <= s2_ah;
      s3_fine <= s2_r.tv ? c3_fine : 32'sd0;
      // stage 4
      s4_r      <= '{temp: c4_t128 >>> 8, fine: s3_fine, pres: s3_r.pres, hum: s3_r.hum,
                     tv: s3_r.tv, pv: s3_r.pv, hv: s3_r.hv};
      s4_ap     <= s3_ap;
      s4_ah     <= s3_ah;
      s4_pa     <= $signed({s3_fine[31], s3_fine}) - 33'sd128000;
      s4_hv     <= s3_fine - 32'sd76800;
      // stage 5
      s5_r   <= s4_r;
      s5_ap  <= s4_ap;
      s5_ah  <= s4_ah;
      s5_aa  <= c5_aa[63:0];
      s5_ap5 <= s4_pa * p5;
      s5_ap2 <= s4_pa * p2;
      s5_h5v <= c5_h5v[31:0];
      s5_vh3 <= c5_vh3[31:0];
      s5_vh6 <= c5_vh6[31:0];
      // stage 6
      s6_r     <= s5_r;
      s6_ap    <= s5_ap;
      s6_aap6  <= c6_aap6[63:0];
      s6_aap3  <= c6_aap3[63:0];
      s6_bpart <= c6_bpart;
      s6_apart <= c6_apart;
      s6_x     <= $signed(c6_x1 + 32'd16384) >>> 15;
      s6_y0    <= (s5_vh3 >>> 11) + 32'sd32768;
      s6_z     <= s5_vh6 >>> 10;
      // stage 7
      s7_r  <= s6_r;
      s7_ap <= s6_ap;
      s7_b  <= s6_aap6 + s6_bpart;
      s7_a2 <= (s6_aap3 >>> 8) + $signed(s6_apart);
      s7_zy <= c7_zy[31:0];
      s7_x  <= s6_x;
      // stage 8
      s8_r   <= s7_r;
      s8_a3p <= c8_a3p[63:0];
      s8_pn  <= {12'd0, c8_pval, 31'd0} - s7_b;
      s8_y2p <= c8_y2p[31:0];
      s8_x   <= s7_x;
      // stage 9
      s9_r   <= s8_r;
      s9_a3  <= s8_a3p[63:33];
      s9_num <= c9_num[63:0];
      s9_y   <= $signed(s8_y2p + 32'd8192) >>> 14;
      s9_x   <= s8_x;
      // stage 10
      s10_r   <= s9_r;
      s10_a3  <= s9_a3;
      s10_num <= s9_num;
      s10_v   <= c10_v[31:0];
      // stage 11
      s11_r   <= s10_r;
      s11_a3  <= s10_a3;
      s11_num <= s10_num;
      s11_v   <= s10_v;
      s11_qq  <= c11_qq[31:0];
      // stage 12
      s12_r   <= s11_r;
      s12_a3  <= s11_a3;
      s12_num <= s11_num;
      s12_v   <= s11_v;
      s12_hp  <= c12_r[31:0];
      // stage 13
      s13_r     <= '{temp: s12_r.temp, fine: s12_r.fine, pres: s12_r.pres,
                     hum: s12_r.hv ? c13_prod[26:10] : 17'd0,
                     tv: s12_r.tv, pv: s12_r.pv, hv: s12_r.hv};
      s13_a3    <= s12_a3;
      s13_num   <= s12_num;
      // tail 1
      u1_r   <= d_r;
      u1_z   <= dz;
      u1_p   <= $signed(dq);
      u1_mq  <= c_u1_mq;
      u1_pm  <= c_u1_pm[63:0];
      u1_p8p <= c_u1_p8p[63:0];
      // tail 2
      u2_r  <= u1_r;
      u2_z  <= u1_z;
      u2_p  <= u1_p;
      u2_ll <= u1_pm[31:0] * u1_mq[31:0];
      u2_cr <= c_u2_c[31:0] + c_u2_d[31:0];
      u2_b2 <= u1_p8p >>> 19;
      // tail 3
      u3_r  <= u2_r;
      u3_z  <= u2_z;
      u3_p  <= u2_p;
      u3_b2 <= u2_b2;
      u3_a  <= $signed(u2_ll + {u2_cr, 32'd0}) >>> 25;
      // tail 4
      u4_r  <= u3_r;
      u4_z  <= u3_z;
      u4_pn <= (c_u4_sum >>> 8) + ($signed({{48{p7[15]}}, p7}) <<< 4);
      // tail 5
      u5_r      <= '{temp: u4_r.temp, fine: u4_r.fine,
                     pres: (u4_r.pv && !u4_z) ? c_u5_x[39:8] : 32'd0,
                     hum: u4_r.hum, tv: u4_r.tv, pv: u4_r.pv, hv: u4_r.hv};
    end
  end

  assign out_push = adv && uv[5];
  assign out_res  = u5_r;

endmodule

// ===== rtl/core/env_sensor_compensation_core.sv =====
// top level of the environmental sensor compensation core
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  config    | cfg_write             | cfg_index, cfg_data
//  reading   | push / full           | adc_temperature, adc_pressure, adc_humidity
//  result    | empty / pop           | temperature, fine_temperature, pressure,
//            |                       | humidity and the three valid flags
//
//  one reading per cycle sustained while the result queue is not full; a reading
//  passes the front register, the middle queue, 13 compensation stages, the 66-stage
//  pressure divider (the deepest part) and 5 pressure stages into the result queue.
//  rst clears the queues, the stage valids and the calibration registers.
//  a full result queue freezes the whole back pipeline; the front keeps taking
//  readings until the middle queue fills, then full is raised.
module env_sensor_compensation_core #(
  parameter int MID_DEPTH = esc_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = esc_pkg::OUT_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [19:0]                adc_temperature,
  input  logic [19:0]                adc_pressure,
  input  logic [15:0]                adc_humidity,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [31:0]         temperature,
  output logic signed [31:0]         fine_temperature,
  output logic [31:0]                pressure,
  output logic [16:0]                humidity,
  output logic                       temperature_valid,
  output logic                       pressure_valid,
  output logic                       humidity_valid
);
  import esc_pkg::*;

  cal_t    cal;
  item_t   front_item;
  item_t   mid_item;
  result_t back_res;
  result_t out_res;
  logic    mid_push, mid_full, mid_pop, mid_empty;
  logic    out_push, out_full;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HUM_PRESENT: cal.hum_present <= cfg_data[0];
        REG_CAL_TEMP:    cal.temp        <= cfg_data;
        REG_CAL_PRES_A:  cal.pres_a      <= cfg_data;
        REG_CAL_PRES_B:  cal.pres_b      <= cfg_data;
        REG_CAL_PRES_C:  cal.pres_c      <= cfg_data;
        REG_CAL_HUM_A:   cal.hum_a       <= cfg_data[39:0];
        REG_CAL_HUM_B:   cal.hum_b       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // front end
  esc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hum_present(cal.hum_present),
    .push       (push),
    .full       (full),
    .at         (adc_temperature),
    .ap         (adc_pressure),
    .ah         (adc_humidity),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_item   (front_item)
  );

  // queue between front and back
  esc_fifo #(.W($bits(item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .din  (front_item),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_item),
    .empty(mid_empty)
  );

  // compensation pipeline
  esc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cal      (cal),
    .mid_empty(mid_empty),
    .mid_item (mid_item),
    .mid_pop  (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_res  (back_res)
  );

  // result queue
  esc_fifo #(.W($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .din  (back_res),
    .full (out_full),
    .pop  (pop),
    .dout (out_res),
    .empty(empty)
  );

  assign temperature       = out_res.temp;
  assign fine_temperature  = out_res.fine;
  assign pressure          = out_res.pres;
  assign humidity          = out_res.hum;
  assign temperature_valid = out_res.tv;
  assign pressure_valid    = out_res.pv;
  assign humidity_valid    = out_res.hv;

  // skipped temperature clears both temperature fields and the pressure and humidity flags
  a_temp_skip: assert property (@(posedge clk) disable iff (rst)
    !empty && !temperature_valid |-> temperature == 32'sd0 && fine_temperature == 32'sd0
      && !pressure_valid && !humidity_valid)
    else $error("skipped temperature transaction carries data");

  // invalid pressure reads as zero
  a_pres_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !pressure_valid |-> pressure == 32'd0)
    else $error("invalid pressure not zero");

  // humidity stays in range and is zero when invalid
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> humidity <= 17'd100000 && (humidity_valid || humidity == 17'd0))
    else $error("humidity out of range");

  // back end never offers a transaction to a full result queue
  a_out_push: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

endmodule
